// File: rtl/clsc_pkg.sv
package clsc_pkg;

   localparam int LINE_COUNT = 256;
   localparam int INDEX_WIDTH = 8;
   localparam int LOCK_WIDTH = 4;
   localparam logic [LOCK_WIDTH-1:0] MAX_LOCKS = 4'd15;

   localparam logic [2:0] OP_READ = 3'd0;
   localparam logic [2:0] OP_WRITE = 3'd1;
   localparam logic [2:0] OP_LOAD_LOCK = 3'd2;
   localparam logic [2:0] OP_FLUSH = 3'd3;
   localparam logic [2:0] OP_FLUSH_INV = 3'd4;
   localparam logic [2:0] OP_FILL = 3'd5;
   localparam logic [2:0] OP_FLUSH_DONE = 3'd6;
   localparam logic [2:0] OP_EVICT = 3'd7;

   localparam logic [2:0] LS_I = 3'd0;
   localparam logic [2:0] LS_E = 3'd1;
   localparam logic [2:0] LS_M = 3'd2;
   localparam logic [2:0] LS_IS = 3'd3;
   localparam logic [2:0] LS_IM = 3'd4;
   localparam logic [2:0] LS_IB = 3'd5;
   localparam logic [2:0] LS_SB = 3'd6;
   localparam logic [2:0] LS_BAD = 3'd7;

   localparam logic [1:0] KIND_WRITE = 2'd1;

   localparam logic [2:0] DN_NONE = 3'd0;
   localparam logic [2:0] DN_FWD_MISS = 3'd1;
   localparam logic [2:0] DN_PUT_CLEAN = 3'd2;
   localparam logic [2:0] DN_PUT_DIRTY = 3'd3;
   localparam logic [2:0] DN_FLUSH = 3'd4;
   localparam logic [2:0] DN_FLUSH_INV = 3'd5;

   localparam logic [1:0] UP_NONE = 2'd0;
   localparam logic [1:0] UP_READ = 2'd1;
   localparam logic [1:0] UP_WRITE = 2'd2;
   localparam logic [1:0] UP_FLUSH = 2'd3;

   localparam logic [2:0] ACC_NONE = 3'd0;
   localparam logic [2:0] ACC_RD_MISS = 3'd1;
   localparam logic [2:0] ACC_RD_HIT = 3'd2;
   localparam logic [2:0] ACC_WR_MISS = 3'd3;
   localparam logic [2:0] ACC_WR_HIT = 3'd4;

   localparam logic [1:0] PF_NONE = 2'd0;
   localparam logic [1:0] PF_HIT = 2'd1;
   localparam logic [1:0] PF_REDUNDANT = 2'd2;
   localparam logic [1:0] PF_EVICTED = 2'd3;

   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_STATE = 2'd1;
   localparam logic [1:0] ERR_UNLOCK = 2'd2;
   localparam logic [1:0] ERR_OVERFLOW = 2'd3;

   typedef struct packed {
      logic [2:0] op;
      logic [INDEX_WIDTH-1:0] line_index;
      logic line_present;
      logic [1:0] request_kind;
      logic local_prefetch;
      logic load_link;
      logic store_conditional;
      logic unlock_flag;
      logic request_waiting;
      logic flush_ok;
   } req_type;

   typedef struct packed {
      logic stalled;
      logic [2:0] down_message;
      logic flush_dirty;
      logic [1:0] up_message;
      logic success;
      logic merge_store;
      logic [2:0] access_note;
      logic [1:0] prefetch_note;
      logic waits_for_lock;
      logic [1:0] error;
   } rsp_type;

   typedef struct packed {
      logic [2:0] line_state;
      logic [LOCK_WIDTH-1:0] lock_count;
      logic reservation;
      logic prefetch_mark;
   } rec_type;

endpackage

// File: rtl/clsc_engine.sv
module clsc_engine (
   input clsc_pkg::req_type item,
   input clsc_pkg::rec_type rec,
   input logic writeback_clean,
   output clsc_pkg::rec_type rec_next,
   output clsc_pkg::rsp_type result
);
   import clsc_pkg::*;

   logic do_store;
   logic store_write;
   logic clear_res;
   logic [2:0] eff_state;
   logic [2:0] st;

   assign st = rec.line_state;
   assign eff_state = item.line_present ? st : LS_I;

   always_comb begin
      result = '0;
      rec_next = rec;
      do_store = 1'b0;
      store_write = 1'b0;
      clear_res = 1'b0;
      case (item.op)
         OP_READ: begin
            if (st == LS_I) begin
               result.stalled = 1'b1;
               result.down_message = DN_FWD_MISS;
               result.access_note = ACC_RD_MISS;
               rec_next.line_state = LS_IS;
            end else if (st == LS_E || st == LS_M) begin
               result.access_note = ACC_RD_HIT;
               if (item.local_prefetch) begin
                  result.prefetch_note = PF_REDUNDANT;
               end else begin
                  if (rec.prefetch_mark) begin
                     rec_next.prefetch_mark = 1'b0;
                     result.prefetch_note = PF_HIT;
                  end
                  if (item.load_link) begin
                     rec_next.reservation = 1'b1;
                  end
                  result.up_message = UP_READ;
               end
            end else begin
               result.stalled = 1'b1;
               result.error = ERR_STATE;
            end
         end
         OP_WRITE, OP_LOAD_LOCK: begin
            if (st == LS_I) begin
               result.stalled = 1'b1;
               result.down_message = DN_FWD_MISS;
               result.access_note = ACC_WR_MISS;
               rec_next.line_state = LS_IM;
            end else if (st == LS_E || st == LS_M) begin
               rec_next.line_state = LS_M;
               if (rec.prefetch_mark) begin
                  rec_next.prefetch_mark = 1'b0;
                  result.prefetch_note = PF_HIT;
               end
               do_store = 1'b1;
               store_write = (item.op == OP_WRITE);
               clear_res = 1'b1;
            end else begin
               result.stalled = 1'b1;
               result.error = ERR_STATE;
            end
         end
         OP_FLUSH, OP_FLUSH_INV: begin
            if (eff_state == LS_BAD) begin
               result.stalled = 1'b1;
               result.error = ERR_STATE;
            end else if (eff_state >= LS_IS || item.request_waiting) begin
               result.stalled = 1'b1;
            end else if (eff_state != LS_I && rec.lock_count != '0) begin
               result.up_message = UP_FLUSH;
            end else begin
               result.stalled = 1'b1;
               result.down_message = (item.op == OP_FLUSH) ? DN_FLUSH : DN_FLUSH_INV;
               result.flush_dirty = (eff_state == LS_M);
               if (item.line_present) begin
                  if (item.op == OP_FLUSH) begin
                     rec_next.line_state = (eff_state != LS_I) ? LS_SB : LS_IB;
                  end else begin
                     if (rec.prefetch_mark) begin
                        rec_next.prefetch_mark = 1'b0;
                        result.prefetch_note = PF_EVICTED;
                     end
                     rec_next.line_state = LS_IB;
                  end
               end
            end
         end
         OP_FILL: begin
            if (st == LS_IS) begin
               rec_next.line_state = LS_E;
               result.access_note = ACC_RD_HIT;
               if (item.local_prefetch) begin
                  rec_next.prefetch_mark = 1'b1;
               end else begin
                  if (item.load_link) begin
                     rec_next.reservation = 1'b1;
                  end
                  result.up_message = UP_READ;
               end
            end else if (st == LS_IM) begin
               rec_next.line_state = LS_M;
               do_store = 1'b1;
               store_write = (item.request_kind == KIND_WRITE);
            end else begin
               result.stalled = 1'b1;
               result.error = ERR_STATE;
            end
         end
         OP_FLUSH_DONE: begin
            if (item.line_present && st == LS_BAD) begin
               result.stalled = 1'b1;
               result.error = ERR_STATE;
            end else begin
               if (item.line_present && st == LS_SB) begin
                  rec_next.line_state = LS_E;
               end else if (item.line_present && st == LS_IB) begin
                  rec_next.line_state = LS_I;
                  rec_next.reservation = 1'b0;
               end
               result.up_message = UP_FLUSH;
               result.success = item.flush_ok;
            end
         end
         default: begin
            if (rec.lock_count != '0) begin
               result.stalled = 1'b1;
               result.waits_for_lock = 1'b1;
            end else if (st == LS_I) begin
               result.stalled = 1'b0;
            end else if (st == LS_E || st == LS_M) begin
               if (st == LS_M) begin
                  result.down_message = DN_PUT_DIRTY;
               end else if (writeback_clean) begin
                  result.down_message = DN_PUT_CLEAN;
               end
               rec_next.line_state = LS_I;
               rec_next.reservation = 1'b0;
               if (rec.prefetch_mark) begin
                  rec_next.prefetch_mark = 1'b0;
                  result.prefetch_note = PF_EVICTED;
               end
            end else if (st == LS_BAD) begin
               result.stalled = 1'b1;
               result.error = ERR_STATE;
            end else begin
               result.stalled = 1'b1;
            end
         end
      endcase

      if (do_store) begin
         if (store_write) begin
            result.merge_store = !item.store_conditional || rec.reservation;
            result.success = item.store_conditional && rec.reservation;
            if (clear_res) begin
               rec_next.reservation = 1'b0;
            end
            if (item.unlock_flag) begin
               if (rec.lock_count == '0) begin
                  result.error = ERR_UNLOCK;
               end else begin
                  rec_next.lock_count = rec.lock_count - LOCK_WIDTH'(1);
               end
            end
         end else begin
            if (rec.lock_count >= MAX_LOCKS) begin
               result.error = ERR_OVERFLOW;
               rec_next.lock_count = MAX_LOCKS;
            end else begin
               rec_next.lock_count = rec.lock_count + LOCK_WIDTH'(1);
            end
         end
         result.up_message = UP_WRITE;
         result.access_note = ACC_WR_HIT;
      end
   end

endmodule

// File: rtl/cache_line_state_controller_unit.sv
// Results are registered: a transfer reads the line record memory, and the
// update state modifies the record, writes it back and loads the response; no
// new item is taken until that commit, which waits on a stalled response.
// Reset clears the per-line valid bits, so every line reads as invalid with no
// locks, reservation or prefetch mark; writeback_clean resets to zero.
module cache_line_state_controller_unit (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input clsc_pkg::req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output clsc_pkg::rsp_type rsp_data,
   input logic psel,
   input logic penable,
   input logic pwrite,
   input logic [2:0] paddr,
   input logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);
   import clsc_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_UPDATE = 1'b1;

   logic state_ff;
   logic state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic wb_clean_ff;
   logic wb_clean_in;
   logic [LINE_COUNT-1:0] line_valid_ff;
   logic entry_valid_ff;
   req_type item_ff;
   rec_type rd_data_ff;
   rsp_type rsp_ff;
   rec_type rec_mem [LINE_COUNT];

   rec_type cur_rec;
   rec_type new_rec;
   rsp_type new_rsp;
   logic take;
   logic commit;

   assign take = req_valid && !req_stall;
   assign commit = (state_ff == ST_UPDATE) && (!rsp_valid_ff || !rsp_stall);
   assign cur_rec = entry_valid_ff ? rd_data_ff : '0;

   clsc_engine u_engine (
      .item(item_ff),
      .rec(cur_rec),
      .writeback_clean(wb_clean_ff),
      .rec_next(new_rec),
      .result(new_rsp)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      wb_clean_in = wb_clean_ff;
      if (psel && penable && pwrite && paddr[2] == 1'b0) begin
         wb_clean_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         wb_clean_ff <= 1'b0;
         line_valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         wb_clean_ff <= wb_clean_in;
         if (commit) begin
            line_valid_ff[item_ff.line_index] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_data;
         entry_valid_ff <= line_valid_ff[req_data.line_index];
         rd_data_ff <= rec_mem[req_data.line_index];
      end
      if (commit) begin
         rec_mem[item_ff.line_index] <= new_rec;
         rsp_ff <= new_rsp;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign pready = 1'b1;
   assign prdata = (paddr[2] == 1'b0) ? {31'd0, wb_clean_ff} : 32'd0;

endmodule
